@@ design/mrcf_pkg.sv @@
// Shared types, constants and the CRC byte update for the Modbus RTU CRC frame engine.
package mrcf_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // One work item handed from the front to the back through the queue.
  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] crc;
    logic        verdict;
    logic        last;
    logic        match;
  } cmd_t;

  // Register byte 15..8 is the one sent first, so swap around the reflected update.
  function automatic logic [15:0] crc_feed(logic [15:0] reg_v, logic [7:0] b);
    logic [15:0] s;
    s = {reg_v[7:0], reg_v[15:8]} ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (s[0]) begin
        s = (s >> 1) ^ CRC_POLY;
      end else begin
        s = s >> 1;
      end
    end
    return {s[7:0], s[15:8]};
  endfunction

endpackage

@@ design/mrcf_if.sv @@
// Valid/ready channel interfaces for input bytes and result items.
interface mrcf_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output kind, output data_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input last_byte,
                  output ready);
endinterface

interface mrcf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic        end_of_run;
  logic        is_verdict;
  logic        crc_match;
  logic [15:0] crc_value;

  modport source (output valid, output byte_out, output end_of_run, output is_verdict,
                  output crc_match, output crc_value, input ready);
  modport sink   (input valid, input byte_out, input end_of_run, input is_verdict,
                  input crc_match, input crc_value, output ready);
endinterface

@@ design/mrcf_front.sv @@
// Front end: accepts frame bytes, runs the CRC and held-byte state, issues commands.
module mrcf_front (
  input  logic            clk,
  input  logic            rst,
  mrcf_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            push,
  output mrcf_pkg::cmd_t  cmd
);

  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [7:0]  held0;
  logic [7:0]  held0_next;
  logic [7:0]  held1;
  logic [7:0]  held1_next;
  logic [1:0]  seen;
  logic [1:0]  seen_next;
  logic        frame_kind;
  logic        frame_kind_next;
  logic        accept;
  logic        eff_kind;
  logic [15:0] crc_gen;
  logic [15:0] crc_chk;
  logic [1:0]  seen_sat;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign eff_kind    = (seen == 2'd0) ? in_ch.kind : frame_kind;
  assign crc_gen     = mrcf_pkg::crc_feed(crc, in_ch.data_byte);
  assign crc_chk     = (seen == 2'd2) ? mrcf_pkg::crc_feed(crc, held0) : crc;
  assign seen_sat    = (seen == 2'd2) ? seen : seen + 2'd1;

  always_comb begin
    crc_next        = crc;
    held0_next      = held0;
    held1_next      = held1;
    seen_next       = seen;
    frame_kind_next = frame_kind;
    push            = 1'b0;
    cmd             = '0;
    if (accept) begin
      if (!eff_kind) begin
        push        = 1'b1;
        cmd.data    = in_ch.data_byte;
        cmd.crc     = crc_gen;
        cmd.last    = in_ch.last_byte;
        crc_next    = crc_gen;
      end else begin
        crc_next    = crc_chk;
        held0_next  = held1;
        held1_next  = in_ch.data_byte;
        if (in_ch.last_byte) begin
          push        = 1'b1;
          cmd.verdict = 1'b1;
          cmd.last    = 1'b1;
          cmd.crc     = crc_chk;
          cmd.match   = (seen != 2'd0) && ({held1, in_ch.data_byte} == crc_chk);
        end
      end
      seen_next       = seen_sat;
      frame_kind_next = eff_kind;
      if (in_ch.last_byte) begin
        crc_next        = mrcf_pkg::CRC_INIT;
        held0_next      = 8'h00;
        held1_next      = 8'h00;
        seen_next       = 2'd0;
        frame_kind_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc        <= mrcf_pkg::CRC_INIT;
      held0      <= 8'h00;
      held1      <= 8'h00;
      seen       <= 2'd0;
      frame_kind <= 1'b0;
    end else begin
      crc        <= crc_next;
      held0      <= held0_next;
      held1      <= held1_next;
      seen       <= seen_next;
      frame_kind <= frame_kind_next;
    end
  end

endmodule

@@ design/mrcf_queue.sv @@
// Short command queue between the front and back ends.
module mrcf_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mrcf_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output mrcf_pkg::cmd_t  head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mrcf_pkg::cmd_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ design/mrcf_back.sv @@
// Back end: expands commands into result items behind a registered output.
module mrcf_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  mrcf_pkg::cmd_t  head,
  output logic            pop,
  mrcf_out_if.source      out_ch
);

  typedef enum logic [1:0] {
    PH_ECHO,
    PH_HIGH,
    PH_LOW
  } phase_t;

  phase_t phase;
  logic   load;
  logic   take;
  logic   triple;

  assign load   = !out_ch.valid || out_ch.ready;
  assign take   = q_valid && load;
  assign triple = !head.verdict && head.last;
  assign pop    = take && (!triple || (phase == PH_LOW));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_ECHO;
      out_ch.valid <= 1'b0;
    end else begin
      if (load) begin
        out_ch.valid <= q_valid;
      end
      if (take) begin
        out_ch.crc_value  <= head.crc;
        out_ch.is_verdict <= head.verdict;
        out_ch.crc_match  <= head.match;
        case (phase)
          PH_ECHO: begin
            out_ch.byte_out   <= head.data;
            out_ch.end_of_run <= head.last && head.verdict;
            if (triple) begin
              phase <= PH_HIGH;
            end
          end
          PH_HIGH: begin
            out_ch.byte_out   <= head.crc[15:8];
            out_ch.end_of_run <= 1'b0;
            phase             <= PH_LOW;
          end
          PH_LOW: begin
            out_ch.byte_out   <= head.crc[7:0];
            out_ch.end_of_run <= 1'b1;
            phase             <= PH_ECHO;
          end
          default: begin
            phase <= PH_ECHO;
          end
        endcase
      end
    end
  end

endmodule

@@ design/modbus_rtu_crc_frame_engine.sv @@
// Top level of the Modbus RTU CRC-16 frame engine.
// Takes one frame byte per cycle. A byte of kind 0 (generate) is echoed with the running
// CRC; after the last byte the CRC follows, register high byte then low byte, the low byte
// marked end_of_run. A frame of kind 1 (check) gives a single verdict at its last byte,
// comparing the final two bytes (first in the high half) with the CRC of the bytes before
// them; frames of fewer than two bytes report a mismatch. The kind is taken from the first
// byte of each frame. Input bytes are accepted every cycle while the command queue has room;
// the CRC update completes in the cycle of acceptance. The result side issues one item per
// cycle while out_ch.ready does not hold it off, and a generate frame's last byte expands to
// three items (echo, CRC high, CRC low); the queue of QUEUE_DEPTH commands soaks up that
// burst, so new input bytes can be accepted while those items drain.
module modbus_rtu_crc_frame_engine #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  mrcf_in_if.sink     in_ch,
  mrcf_out_if.source  out_ch
);

  logic           push;
  logic           full;
  logic           pop;
  logic           q_valid;
  mrcf_pkg::cmd_t push_cmd;
  mrcf_pkg::cmd_t head;

  mrcf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (full),
    .push   (push),
    .cmd    (push_cmd)
  );

  mrcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  mrcf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
